>>> rtl/chbd_pkg.sv
// Package for the chunked body decoder: op codes, phase and parser codes,
// character constants and register reset values.
// No dependencies; used by every file in rtl/.
package chbd_pkg;

  // Request op codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Decoder phases
  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Size-line parser modes
  localparam logic [2:0] M_BLANK  = 3'd0;
  localparam logic [2:0] M_ZERO   = 3'd1;
  localparam logic [2:0] M_PREFIX = 3'd2;
  localparam logic [2:0] M_DIGITS = 3'd3;
  localparam logic [2:0] M_STOP   = 3'd4;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Register map
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 8'd1;

  localparam logic [16:0] CAPACITY_RESET = 17'd1024;
  localparam logic [31:0] TIMEOUT_RESET  = 32'd10000;

  localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;

  // Default longest stored size line plus one
  localparam int unsigned LINE_LIMIT_DEFAULT = 64;

endpackage

>>> rtl/chbd_size_parser.sv
// One strtol-style step of the chunk-size parser: blanks, optional 0x,
// hex digits with 31-bit saturation. Combinational. Depends on chbd_pkg.
module chbd_size_parser (
  input  logic [2:0]  mode_i,
  input  logic [30:0] accum_i,
  input  logic [7:0]  char_i,
  output logic [2:0]  mode_o,
  output logic [30:0] accum_o
);
  import chbd_pkg::*;

  logic       is_hex;
  logic [3:0] digit;
  logic       is_blank;
  logic [34:0] shifted;

  // Hex digit decode
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      digit = char_i[3:0];
    end else if ((char_i >= 8'h61 && char_i <= 8'h66) ||
                 (char_i >= 8'h41 && char_i <= 8'h46)) begin
      digit = 4'(char_i[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_blank = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
  assign shifted  = {accum_i, 4'b0000} + {31'd0, digit};

  // Mode transitions
  always_comb begin
    mode_o  = mode_i;
    accum_o = accum_i;
    case (mode_i)
      M_BLANK: begin
        if (!is_blank) begin
          if (char_i == CH_ZERO) begin
            accum_o = '0;
            mode_o  = M_ZERO;
          end else if (is_hex) begin
            accum_o = {27'd0, digit};
            mode_o  = M_DIGITS;
          end else begin
            mode_o = M_STOP;
          end
        end
      end
      M_ZERO: begin
        if (char_i == CH_X_LO || char_i == CH_X_UP) begin
          mode_o = M_PREFIX;
        end else if (is_hex) begin
          accum_o = {27'd0, digit};
          mode_o  = M_DIGITS;
        end else begin
          mode_o = M_STOP;
        end
      end
      M_PREFIX: begin
        if (is_hex) begin
          accum_o = {27'd0, digit};
          mode_o  = M_DIGITS;
        end else begin
          mode_o = M_STOP;
        end
      end
      M_DIGITS: begin
        if (!is_hex) begin
          mode_o = M_STOP;
        end else if (shifted[34:31] != 4'd0) begin
          accum_o = SIZE_MAX;
        end else begin
          accum_o = shifted[30:0];
        end
      end
      default: begin
        mode_o = mode_i;
      end
    endcase
  end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: decoder state, config registers
// and the result register. Depends on chbd_pkg and chbd_size_parser.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o     | op_i, data_byte_i
//  result   | out_valid_o / out_ready_i   | payload_*, chunk_done_o, finished_o,
//           |                             | timed_out_o, overflow_error_o,
//           |                             | chunk_size_o, stored_count_o
//  config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One request per cycle while out_ready_i does not stall; its result shows in
// the cycle after acceptance. The state update and the two chained parser
// steps are combinational ahead of the result register. in_ready_o is high
// whenever the result register is empty or being drained, so stalls only come
// from out_ready_i. Reset leaves the decoder finished with the default
// capacity and timeout. Config is always ready.
module http_chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT = chbd_pkg::LINE_LIMIT_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            payload_valid_o,
  output logic [7:0]                      payload_byte_o,
  output logic [15:0]                     payload_offset_o,
  output logic                            chunk_done_o,
  output logic                            finished_o,
  output logic                            timed_out_o,
  output logic                            overflow_error_o,
  output logic [30:0]                     chunk_size_o,
  output logic [15:0]                     stored_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [chbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import chbd_pkg::*;

  localparam int unsigned LL_W = $clog2(LINE_LIMIT);
  localparam logic [LL_W-1:0] LL_MAX = LL_W'(LINE_LIMIT - 1);

  logic [16:0] capacity_q;
  logic [31:0] timeout_q;

  logic [1:0]      phase_q, phase_d;
  logic [30:0]     accum_q, accum_d;
  logic [2:0]      mode_q, mode_d;
  logic [LL_W-1:0] line_len_q, line_len_d;
  logic            last_cr_q, last_cr_d;
  logic [30:0]     bic_q, bic_d;
  logic [15:0]     wr_off_q, wr_off_d;
  logic [31:0]     total_q, total_d;
  logic [31:0]     idle_q, idle_d;
  logic            tmo_q, tmo_d;

  logic            out_valid_q;
  logic            pv_q, pv_d;
  logic [7:0]      pbyte_q, pbyte_d;
  logic [15:0]     poff_q, poff_d;
  logic            done_q, done_d;
  logic            fin_q;
  logic            tmo_out_q;
  logic            ovf_q, ovf_d;
  logic [30:0]     size_out_q;
  logic [15:0]     cnt_out_q;

  logic            accept;
  logic [2:0]      cr_mode, mid_mode, ch_mode;
  logic [30:0]     cr_accum, mid_accum, ch_accum;
  logic [16:0]     limit;
  logic [30:0]     bic_inc;
  logic [31:0]     idle_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CAPACITY) begin
        capacity_q <= cfg_data_i[16:0];
      end else if (cfg_index_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // A pending CR is parsed first, then the new character
  chbd_size_parser u_cr_step (
    .mode_i  (mode_q),
    .accum_i (accum_q),
    .char_i  (CH_CR),
    .mode_o  (cr_mode),
    .accum_o (cr_accum)
  );

  assign mid_mode  = last_cr_q ? cr_mode : mode_q;
  assign mid_accum = last_cr_q ? cr_accum : accum_q;

  chbd_size_parser u_char_step (
    .mode_i  (mid_mode),
    .accum_i (mid_accum),
    .char_i  (data_byte_i),
    .mode_o  (ch_mode),
    .accum_o (ch_accum)
  );

  // Store limit: capacity minus one, clamped to the offset range
  always_comb begin
    if (capacity_q == 17'd0) begin
      limit = 17'd0;
    end else if (capacity_q > 17'h1_0000) begin
      limit = 17'h0_FFFF;
    end else begin
      limit = capacity_q - 17'd1;
    end
  end

  assign bic_inc  = bic_q + 31'd1;
  assign idle_inc = (idle_q == 32'hFFFF_FFFF) ? idle_q : idle_q + 32'd1;

  // Next decoder state and result fields
  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    mode_d     = mode_q;
    line_len_d = line_len_q;
    last_cr_d  = last_cr_q;
    bic_d      = bic_q;
    wr_off_d   = wr_off_q;
    total_d    = total_q;
    idle_d     = idle_q;
    tmo_d      = tmo_q;
    pv_d       = 1'b0;
    pbyte_d    = 8'd0;
    poff_d     = 16'd0;
    done_d     = 1'b0;
    if (op_i == OP_START) begin
      phase_d    = PH_SIZE;
      accum_d    = '0;
      mode_d     = M_BLANK;
      line_len_d = '0;
      last_cr_d  = 1'b0;
      bic_d      = '0;
      wr_off_d   = '0;
      total_d    = '0;
      idle_d     = '0;
      tmo_d      = 1'b0;
    end else if (op_i == OP_BYTE && phase_q != PH_DONE) begin
      idle_d = '0;
      case (phase_q)
        PH_SIZE: begin
          if (data_byte_i == CH_LF && last_cr_q) begin
            total_d    = total_q + {1'b0, accum_q};
            bic_d      = '0;
            line_len_d = '0;
            last_cr_d  = 1'b0;
            phase_d    = (accum_q == 31'd0) ? PH_WAIT : PH_DATA;
          end else if (line_len_q < LL_MAX) begin
            line_len_d = line_len_q + 1'b1;
            if (data_byte_i == CH_CR) begin
              last_cr_d = 1'b1;
              mode_d    = mid_mode;
              accum_d   = mid_accum;
            end else begin
              last_cr_d = 1'b0;
              mode_d    = ch_mode;
              accum_d   = ch_accum;
            end
          end
        end
        PH_DATA: begin
          bic_d = bic_inc;
          if ({1'b0, wr_off_q} < limit) begin
            pv_d     = 1'b1;
            pbyte_d  = data_byte_i;
            poff_d   = wr_off_q;
            wr_off_d = wr_off_q + 16'd1;
          end
          if (bic_inc == accum_q) begin
            done_d  = 1'b1;
            phase_d = PH_WAIT;
          end
        end
        default: begin
          // Waiting for the LF that closes a chunk
          if (data_byte_i == CH_LF) begin
            if (accum_q == 31'd0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d    = PH_SIZE;
              accum_d    = '0;
              mode_d     = M_BLANK;
              line_len_d = '0;
              last_cr_d  = 1'b0;
            end
          end
        end
      endcase
    end else if (op_i == OP_TICK && phase_q != PH_DONE) begin
      idle_d = idle_inc;
      if (idle_inc >= timeout_q) begin
        phase_d = PH_DONE;
        tmo_d   = 1'b1;
      end
    end
    ovf_d = (phase_d == PH_DONE) && !tmo_d && ({16'd0, wr_off_d} < total_d);
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DONE;
      accum_q    <= '0;
      mode_q     <= M_BLANK;
      line_len_q <= '0;
      last_cr_q  <= 1'b0;
      bic_q      <= '0;
      wr_off_q   <= '0;
      total_q    <= '0;
      idle_q     <= '0;
      tmo_q      <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      mode_q     <= mode_d;
      line_len_q <= line_len_d;
      last_cr_q  <= last_cr_d;
      bic_q      <= bic_d;
      wr_off_q   <= wr_off_d;
      total_q    <= total_d;
      idle_q     <= idle_d;
      tmo_q      <= tmo_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pv_q       <= pv_d;
      pbyte_q    <= pbyte_d;
      poff_q     <= poff_d;
      done_q     <= done_d;
      fin_q      <= (phase_d == PH_DONE);
      tmo_out_q  <= tmo_d;
      ovf_q      <= ovf_d;
      size_out_q <= accum_d;
      cnt_out_q  <= wr_off_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = pv_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_offset_o = poff_q;
  assign chunk_done_o     = done_q;
  assign finished_o       = fin_q;
  assign timed_out_o      = tmo_out_q;
  assign overflow_error_o = ovf_q;
  assign chunk_size_o     = size_out_q;
  assign stored_count_o   = cnt_out_q;

endmodule

>>> rtl/chbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on chbd_pkg and http_chunked_body_decoder.
module chbd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           payload_valid_o,
  input logic [15:0]                    payload_offset_o,
  input logic                           finished_o,
  input logic                           timed_out_o,
  input logic [15:0]                    stored_count_o
);
  import chbd_pkg::*;

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  // Stored data never comes from a finished body
  a_data_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> !finished_o)
    else $error("payload byte after finish");

  // The count covers the byte just stored
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> stored_count_o == 16'(payload_offset_o + 16'd1))
    else $error("stored count out of step with offset");

  // A timeout always ends the body
  a_tmo_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timed_out_o |-> finished_o)
    else $error("timeout without finish");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .payload_valid_o  (payload_valid_o),
  .payload_offset_o (payload_offset_o),
  .finished_o       (finished_o),
  .timed_out_o      (timed_out_o),
  .stored_count_o   (stored_count_o)
);
